[sv/srle_pkg.sv]
// Shared types, constants and sizes of the sixel run-length encoder.
`timescale 1ns / 1ps

package srle_pkg;

    // Field and state widths
    localparam int PIX_W       = 12;
    localparam int ROWS_W      = 3;
    localparam int COLOR_W     = 2;
    localparam int BYTE_W      = 7;
    localparam int RUN_W       = 13;
    localparam int SIXEL_ROWS  = 6;
    localparam int MAX_WIDTH_D = 4096;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // Stream characters
    localparam logic [BYTE_W-1:0] CH_BANG    = 7'h21;
    localparam logic [BYTE_W-1:0] CH_HASH    = 7'h23;
    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 7'h24;
    localparam logic [BYTE_W-1:0] CH_DASH    = 7'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 7'h30;
    localparam logic [BYTE_W-1:0] SIXEL_BIAS = 7'h3F;
    localparam logic [BYTE_W-1:0] CH_TOP     = 7'h7E;

    // Segments of output one column can produce, in emission order
    typedef struct packed {
        logic hdr;     // '#' and color digit
        logic run0;    // run broken by this column
        logic run1;    // run closed by the last column
        logic dollar;  // carriage return
        logic dash;    // graphics newline
    } seg_mask_t;

    typedef struct packed {
        seg_mask_t               segs;
        logic [COLOR_W-1:0]      color;
        logic [RUN_W-1:0]        run0_len;
        logic [BYTE_W-1:0]       run0_char;
        logic [RUN_W-1:0]        run1_len;
        logic [BYTE_W-1:0]       run1_char;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_HASH,
        BK_COLOR,
        BK_BANG,
        BK_DIGIT,
        BK_RCHAR,
        BK_DOLLAR,
        BK_DASH
    } bk_state_t;

    // Back-end state loaded when a segment starts
    typedef struct packed {
        bk_state_t          state;
        seg_mask_t          rest;
        logic [RUN_W-1:0]   val;
        logic [BYTE_W-1:0]  ch;
        logic               long_run;
        logic [1:0]         rep;
        logic [1:0]         place;
    } entry_t;

endpackage

[sv/srle_front.sv]
// Front end: builds the sixel character, tracks the run and issues commands.
`timescale 1ns / 1ps

module srle_front #(
    parameter int MAX_WIDTH = srle_pkg::MAX_WIDTH_D
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [srle_pkg::PIX_W-1:0]  column_pixels,
    input  logic [srle_pkg::ROWS_W-1:0] valid_rows,
    input  logic [srle_pkg::COLOR_W-1:0] pass_color,
    input  logic                        first_column,
    input  logic                        last_column,
    input  logic                        band_end,
    input  logic                        q_full,
    output logic                        push,
    output srle_pkg::cmd_t              cmd
);
    import srle_pkg::*;

    localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_WIDTH);

    logic [RUN_W-1:0]  run_len_reg, run_len_next;
    logic [BYTE_W-1:0] run_ch_reg, run_ch_next;

    logic                       accept;
    logic [ROWS_W-1:0]          rows;
    logic [SIXEL_ROWS-1:0]      mask;
    logic [BYTE_W-1:0]          ch;
    logic [RUN_W-1:0]           rl;
    logic [RUN_W-1:0]           rl_upd;
    logic [BYTE_W-1:0]          ch_upd;
    logic                       extend;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign rows     = (valid_rows > ROWS_W'(SIXEL_ROWS)) ? ROWS_W'(SIXEL_ROWS) : valid_rows;

    always_comb
    begin
        for (int r = 0; r < SIXEL_ROWS; r++)
        begin
            mask[r] = (ROWS_W'(r) < rows) && (column_pixels[2*r +: 2] == pass_color);
        end
    end

    assign ch     = SIXEL_BIAS + {1'b0, mask};
    assign rl     = first_column ? '0 : run_len_reg;
    assign extend = (rl != '0) && (ch == run_ch_reg);
    assign rl_upd = extend ? ((rl < RUN_MAX) ? rl + 1'b1 : rl) : RUN_W'(1);
    assign ch_upd = extend ? run_ch_reg : ch;

    always_comb
    begin
        cmd.segs.hdr    = first_column;
        cmd.segs.run0   = !extend && (rl != '0);
        cmd.segs.run1   = last_column;
        cmd.segs.dollar = last_column;
        cmd.segs.dash   = last_column && band_end;
        cmd.color       = pass_color;
        cmd.run0_len    = rl;
        cmd.run0_char   = run_ch_reg;
        cmd.run1_len    = rl_upd;
        cmd.run1_char   = ch_upd;
    end

    // Columns that only extend a run push nothing
    assign push = accept && (cmd.segs != '0);

    always_comb
    begin
        run_len_next = run_len_reg;
        run_ch_next  = run_ch_reg;
        if (accept)
        begin
            run_len_next = last_column ? '0 : rl_upd;
            run_ch_next  = ch_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg <= '0;
            run_ch_reg  <= '0;
        end
        else
        begin
            run_len_reg <= run_len_next;
            run_ch_reg  <= run_ch_next;
        end
    end

endmodule

[sv/srle_cmd_fifo.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module srle_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  srle_pkg::cmd_t push_cmd,
    input  logic           pop,
    output srle_pkg::cmd_t head,
    output logic           empty,
    output logic           full
);
    import srle_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/srle_back.sv]
// Back end: expands commands into stream bytes, one per cycle unless stalled.
`timescale 1ns / 1ps

module srle_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  srle_pkg::cmd_t              head,
    input  logic                        q_empty,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [srle_pkg::BYTE_W-1:0] out_byte,
    output logic                        last_byte
);
    import srle_pkg::*;

    bk_state_t         state_reg, state_next;
    seg_mask_t         pend_reg, pend_next;
    cmd_t              cmd_reg, cmd_next;
    logic [RUN_W-1:0]  val_reg, val_next;
    logic [BYTE_W-1:0] ch_reg, ch_next;
    logic              long_reg, long_next;
    logic [1:0]        rep_reg, rep_next;
    logic [1:0]        place_reg, place_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              last_byte_reg, last_byte_next;

    logic              can_emit;
    logic              emitting;
    logic              seg_done;
    logic              cmd_done;
    logic [BYTE_W-1:0] byte_val;
    logic [3:0]        digit;
    logic [RUN_W-1:0]  digit_rem;
    entry_t            ent_head;
    entry_t            ent_pend;

    // k * 10^place for the digit compare
    function automatic logic [RUN_W:0] kp(input logic [1:0] place, input int k);
        logic [RUN_W:0] r;
        case (place)
            2'd0:    r = (RUN_W+1)'(k);
            2'd1:    r = (RUN_W+1)'(k * 10);
            2'd2:    r = (RUN_W+1)'(k * 100);
            2'd3:    r = (RUN_W+1)'(k * 1000);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic entry_t enter_seg(input seg_mask_t segs, input cmd_t c);
        entry_t            e;
        logic              take;
        logic [RUN_W-1:0]  len;
        logic [BYTE_W-1:0] rch;
        e     = '0;
        e.rest = segs;
        take  = 1'b0;
        len   = '0;
        rch   = '0;
        if (segs.hdr)
        begin
            e.state    = BK_HASH;
            e.rest.hdr = 1'b0;
        end
        else if (segs.run0)
        begin
            take        = 1'b1;
            len         = c.run0_len;
            rch         = c.run0_char;
            e.rest.run0 = 1'b0;
        end
        else if (segs.run1)
        begin
            take        = 1'b1;
            len         = c.run1_len;
            rch         = c.run1_char;
            e.rest.run1 = 1'b0;
        end
        else if (segs.dollar)
        begin
            e.state       = BK_DOLLAR;
            e.rest.dollar = 1'b0;
        end
        else if (segs.dash)
        begin
            e.state     = BK_DASH;
            e.rest.dash = 1'b0;
        end
        else
        begin
            e.state = BK_IDLE;
        end
        if (take)
        begin
            e.val      = len;
            e.ch       = rch;
            e.long_run = (len >= RUN_W'(4));
            e.rep      = len[1:0];
            e.place    = (len >= RUN_W'(1000)) ? 2'd3 :
                         (len >= RUN_W'(100))  ? 2'd2 :
                         (len >= RUN_W'(10))   ? 2'd1 : 2'd0;
            e.state    = e.long_run ? BK_BANG : BK_RCHAR;
        end
        return e;
    endfunction

    assign can_emit = !out_valid_reg || !out_stall;
    assign emitting = (state_reg != BK_IDLE) && can_emit;
    assign ent_head = enter_seg(head.segs, head);
    assign ent_pend = enter_seg(pend_reg, cmd_reg);

    always_comb
    begin
        case (state_reg)
            BK_COLOR:  seg_done = 1'b1;
            BK_DOLLAR: seg_done = 1'b1;
            BK_DASH:   seg_done = 1'b1;
            BK_RCHAR:  seg_done = long_reg || (rep_reg == 2'd1);
            default:   seg_done = 1'b0;
        endcase
    end

    assign cmd_done = emitting && seg_done && (pend_reg == '0);
    assign pop      = !q_empty && ((state_reg == BK_IDLE) || cmd_done);

    // Leading decimal digit of the remaining count
    always_comb
    begin
        digit     = '0;
        digit_rem = val_reg;
        for (int k = 1; k <= 9; k++)
        begin
            if ({1'b0, val_reg} >= kp(place_reg, k))
            begin
                digit     = 4'(k);
                digit_rem = RUN_W'({1'b0, val_reg} - kp(place_reg, k));
            end
        end
    end

    // Output decode
    always_comb
    begin
        case (state_reg)
            BK_HASH:   byte_val = CH_HASH;
            BK_COLOR:  byte_val = CH_ZERO + BYTE_W'(cmd_reg.color);
            BK_BANG:   byte_val = CH_BANG;
            BK_DIGIT:  byte_val = CH_ZERO + BYTE_W'(digit);
            BK_RCHAR:  byte_val = ch_reg;
            BK_DOLLAR: byte_val = CH_DOLLAR;
            BK_DASH:   byte_val = CH_DASH;
            default:   byte_val = '0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        ch_next    = ch_reg;
        long_next  = long_reg;
        rep_next   = rep_reg;
        place_next = place_reg;
        if (state_reg == BK_IDLE || (emitting && seg_done))
        begin
            if (state_reg != BK_IDLE && pend_reg != '0)
            begin
                state_next = ent_pend.state;
                pend_next  = ent_pend.rest;
                val_next   = ent_pend.val;
                ch_next    = ent_pend.ch;
                long_next  = ent_pend.long_run;
                rep_next   = ent_pend.rep;
                place_next = ent_pend.place;
            end
            else if (pop)
            begin
                cmd_next   = head;
                state_next = ent_head.state;
                pend_next  = ent_head.rest;
                val_next   = ent_head.val;
                ch_next    = ent_head.ch;
                long_next  = ent_head.long_run;
                rep_next   = ent_head.rep;
                place_next = ent_head.place;
            end
            else
            begin
                state_next = BK_IDLE;
            end
        end
        else if (emitting)
        begin
            case (state_reg)
                BK_HASH:  state_next = BK_COLOR;
                BK_BANG:  state_next = BK_DIGIT;
                BK_DIGIT:
                begin
                    val_next = digit_rem;
                    if (place_reg == 2'd0)
                    begin
                        state_next = BK_RCHAR;
                    end
                    else
                    begin
                        place_next = place_reg - 1'b1;
                    end
                end
                BK_RCHAR: rep_next = rep_reg - 1'b1;
                default:  state_next = state_reg;
            endcase
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_byte_next = last_byte_reg;
        if (emitting)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = byte_val;
            last_byte_next = cmd_done;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        val_reg       <= val_next;
        ch_reg        <= ch_next;
        long_reg      <= long_next;
        rep_reg       <= rep_next;
        place_reg     <= place_next;
        out_byte_reg  <= out_byte_next;
        last_byte_reg <= last_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

[sv/sixel_color_pass_rle_encoder_unit.sv]
// Top level of the sixel color-pass run-length encoder.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid / in_stall): one pixel column per transfer, with
//   the pass color and the first/last column and band-end markers.
//   Output channel (out_valid / out_stall): one ASCII byte per transfer;
//   last_byte marks the final byte caused by a column. A column that only
//   extends a pending run causes no byte at all.
//   Path: when the back end is idle, the first byte of a column passes
//   through the command queue, the back-end state and the output register.
//   Throughput: the front end takes one column per cycle while the
//   four-entry command queue has room; the back end writes one byte per
//   cycle while the output is not stalled, and a column causes 0 to 9 bytes.
//   The byte sequencer in the back end sets the sustained rate; run counts
//   are written one decimal digit per cycle while the output is not stalled.
//   Reset: the pending run is cleared, the queue empties, no byte is valid.
//   Receiver stall: the output byte holds; the back end waits, the queue
//   fills, and then in_stall rises until a command slot frees up.
module sixel_color_pass_rle_encoder_unit #(
    parameter int MAX_WIDTH = srle_pkg::MAX_WIDTH_D
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [srle_pkg::PIX_W-1:0]   column_pixels,
    input  logic [srle_pkg::ROWS_W-1:0]  valid_rows,
    input  logic [srle_pkg::COLOR_W-1:0] pass_color,
    input  logic                         first_column,
    input  logic                         last_column,
    input  logic                         band_end,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [srle_pkg::BYTE_W-1:0]  out_byte,
    output logic                         last_byte
);
    import srle_pkg::*;

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    // Classify columns and track the run
    srle_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .column_pixels (column_pixels),
        .valid_rows    (valid_rows),
        .pass_color    (pass_color),
        .first_column  (first_column),
        .last_column   (last_column),
        .band_end      (band_end),
        .q_full        (q_full),
        .push          (q_push),
        .cmd           (push_cmd)
    );

    // Decouples column intake from byte output
    srle_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head     (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // Byte sequencer
    srle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_cmd),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

[sv/srle_checker.sv]
// Port-level checks on the encoder output stream, bound to the top level.
`timescale 1ns / 1ps

module srle_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [srle_pkg::BYTE_W-1:0] out_byte,
    input logic                        last_byte
);
    import srle_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_byte))
        else $error("output changed while stalled");

    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_byte >= CH_BANG) && (out_byte <= CH_TOP))
        else $error("byte outside sixel alphabet");

    a_dash_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_byte == CH_DASH) |-> last_byte)
        else $error("graphics newline not last byte of column");

    a_prefix_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((out_byte == CH_HASH) || (out_byte == CH_BANG)) |-> !last_byte)
        else $error("color select or repeat mark ends a column");

endmodule

bind sixel_color_pass_rle_encoder_unit srle_checker u_srle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .last_byte (last_byte)
);
